>>> sv/epoch_seconds_to_civil_date_top_assert.svh
// assertion macros for the epoch-to-date converter
// expects i_clk and i_rst_n in the scope of the module that includes it
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define ESD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/esd_pkg.sv
// constants and types for the epoch-to-date converter
// reciprocal multipliers for the constant divisions; no dependencies
package esd_pkg;

    // field widths
    localparam int EpochW  = 32;
    localparam int YearW   = 12;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;

    // pipeline depth, input register through result register
    localparam int Stages = 10;

    // day 11017 after the epoch is 2000-03-01, the start of the next 400-year era
    localparam logic [15:0] EraSplitDay  = 16'd11017;
    localparam logic [17:0] DoeOffsetLo  = 18'd135080;
    localparam logic [17:0] DaysPerEra   = 18'd146097;
    localparam logic [17:0] DaysEraLast  = 18'd146096;
    localparam logic [11:0] EraLoYear    = 12'd1600;
    localparam logic [11:0] EraHiYear    = 12'd2000;

    // ceil(2^k / d), exact floor division for inputs below 2^(k - ceil(log2 d))
    localparam logic [30:0] RcpDiv15Sec  = 31'(((64'd1 << 34) + 64'd14) / 64'd15);
    localparam logic [25:0] RcpDiv15Min  = 26'(((64'd1 << 29) + 64'd14) / 64'd15);
    localparam logic [18:0] RcpDiv3      = 19'(((64'd1 << 20) + 64'd2) / 64'd3);
    localparam logic [18:0] RcpDiv1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RcpDiv36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] RcpDiv365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  RcpDiv100    = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] RcpDiv153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [11:0] RcpDiv5      = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

    // time of day carried alongside the date stages
    typedef struct packed {
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } t_tod;

endpackage

>>> sv/epoch_seconds_to_civil_date_top.sv
// Unix seconds to proleptic Gregorian date and time of day
// Uses esd_pkg and epoch_seconds_to_civil_date_top_assert.svh
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries i_epoch_seconds, an unsigned
//   count of seconds since 1970-01-01 00:00:00 UTC. Output channel
//   o_out_valid / i_out_ready carries year, month, day, hour, minute, second.
//   A transfer happens on a rising edge with valid and ready both high.
//   o_out_valid rises once the conversion has passed the input register,
//   eight stages of reciprocal multiplies and small adds, and the result
//   register. Throughput is one conversion per cycle while the receiver
//   takes results. The pipeline advances as a whole: when a result sits
//   unaccepted in the output register, every stage holds and o_in_ready
//   drops in the same cycle; nothing is lost or repeated. Reset
//   (synchronous, active low) clears all stage valid flags, dropping
//   anything in flight; there is no configuration and no state kept
//   between conversions.
module epoch_seconds_to_civil_date_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [esd_pkg::EpochW-1:0]    i_epoch_seconds,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [esd_pkg::YearW-1:0]     o_year,
    output logic [esd_pkg::MonthW-1:0]    o_month,
    output logic [esd_pkg::DayW-1:0]      o_day,
    output logic [esd_pkg::HourW-1:0]     o_hour,
    output logic [esd_pkg::MinuteW-1:0]   o_minute,
    output logic [esd_pkg::SecondW-1:0]   o_second
);

    `include "epoch_seconds_to_civil_date_top_assert.svh"

    logic                      w_en;
    logic [esd_pkg::Stages-1:0] r_vld;

    // stage payload registers
    logic [31:0]          r_s0;
    logic [31:0]          r_s1;
    logic [26:0]          r_min1;
    logic [5:0]           r_sec2;
    logic [26:0]          r_min2;
    logic [20:0]          r_hr2;
    logic [5:0]           r_sec3;
    logic [5:0]           r_minute3;
    logic [20:0]          r_hr3;
    logic [15:0]          r_day3;
    esd_pkg::t_tod        r_tod [5];
    logic                 r_era [5];
    logic [17:0]          r_doe4;
    logic [17:0]          r_doe5;
    logic [17:0]          r_yn5;
    logic [17:0]          r_doe6;
    logic [8:0]           r_yoe6;
    logic [8:0]           r_doy7;
    logic [8:0]           r_yoe7;
    logic [8:0]           r_doy8;
    logic [8:0]           r_yoe8;
    logic [3:0]           r_mp8;
    logic [esd_pkg::YearW-1:0]   r_year;
    logic [esd_pkg::MonthW-1:0]  r_month;
    logic [esd_pkg::DayW-1:0]    r_day;
    logic [esd_pkg::HourW-1:0]   r_hour;
    logic [esd_pkg::MinuteW-1:0] r_minute;
    logic [esd_pkg::SecondW-1:0] r_second;

    // next values
    logic [60:0]          n_p_min;
    logic [26:0]          n_min1;
    logic [5:0]           n_sec2;
    logic [50:0]          n_p_hr;
    logic [20:0]          n_hr2;
    logic [5:0]           n_minute3;
    logic [36:0]          n_p_day;
    logic [15:0]          n_day3;
    logic [4:0]           n_hour4;
    logic                 n_era4;
    logic [17:0]          n_doe4;
    logic [36:0]          n_p_c1460;
    logic [36:0]          n_p_c36524;
    logic [6:0]           n_q1460;
    logic [2:0]           n_q36524;
    logic                 n_last;
    logic [17:0]          n_yn5;
    logic [36:0]          n_p_yoe;
    logic [8:0]           n_yoe6;
    logic [18:0]          n_p_c100;
    logic [1:0]           n_q100;
    logic [17:0]          n_doy_w;
    logic [8:0]           n_doy7;
    logic [10:0]          n_mx;
    logic [22:0]          n_p_mp;
    logic [3:0]           n_mp8;
    logic [10:0]          n_dx;
    logic [22:0]          n_p_dq;
    logic [8:0]           n_dq;
    logic [esd_pkg::DayW-1:0]   n_day9;
    logic [esd_pkg::MonthW-1:0] n_month9;
    logic [esd_pkg::YearW-1:0]  n_year9;

    // whole pipeline moves unless a result is stuck in the output register
    assign w_en       = !r_vld[esd_pkg::Stages-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[esd_pkg::Stages-2:0], i_in_valid};
        end
    end

    // stage 1: s / 60
    assign n_p_min = 61'(r_s0[31:2]) * 61'(esd_pkg::RcpDiv15Sec);
    assign n_min1  = n_p_min[60:34];

    // stage 2: second, and s / 3600
    assign n_sec2 = 6'(r_s1 - 32'(r_min1) * 32'd60);
    assign n_p_hr = 51'(r_min1[26:2]) * 51'(esd_pkg::RcpDiv15Min);
    assign n_hr2  = n_p_hr[49:29];

    // stage 3: minute, and whole days
    assign n_minute3 = 6'(r_min2 - 27'(r_hr2) * 27'd60);
    assign n_p_day   = 37'(r_hr2[20:3]) * 37'(esd_pkg::RcpDiv3);
    assign n_day3    = n_p_day[35:20];

    // stage 4: hour, and day of era (inputs span only two eras)
    assign n_hour4 = 5'(r_hr3 - 21'(r_day3) * 21'd24);
    assign n_era4  = (r_day3 >= esd_pkg::EraSplitDay);
    assign n_doe4  = n_era4 ? (18'(r_day3) - 18'(esd_pkg::EraSplitDay))
                            : (18'(r_day3) + esd_pkg::DoeOffsetLo);

    // stage 5: leap corrections inside the era
    assign n_p_c1460  = 37'(r_doe4) * 37'(esd_pkg::RcpDiv1460);
    assign n_p_c36524 = 37'(r_doe4) * 37'(esd_pkg::RcpDiv36524);
    assign n_q1460    = n_p_c1460[35:29];
    assign n_q36524   = n_p_c36524[36:34];
    assign n_last     = (r_doe4 == esd_pkg::DaysEraLast);
    assign n_yn5      = r_doe4 - 18'(n_q1460) + 18'(n_q36524) - 18'(n_last);

    // stage 6: year of era
    assign n_p_yoe = 37'(r_yn5) * 37'(esd_pkg::RcpDiv365);
    assign n_yoe6  = n_p_yoe[35:27];

    // stage 7: day of the march-based year
    assign n_p_c100 = 19'(r_yoe6) * 19'(esd_pkg::RcpDiv100);
    assign n_q100   = n_p_c100[17:16];
    assign n_doy_w  = r_doe6 - (18'(r_yoe6) * 18'd365 + 18'(r_yoe6[8:2]) - 18'(n_q100));
    assign n_doy7   = n_doy_w[8:0];

    // stage 8: march-based month index
    assign n_mx    = 11'(r_doy7) * 11'd5 + 11'd2;
    assign n_p_mp  = 23'(n_mx) * 23'(esd_pkg::RcpDiv153);
    assign n_mp8   = n_p_mp[22:19];

    // stage 9: day of month, civil month and year
    assign n_dx     = 11'(r_mp8) * 11'd153 + 11'd2;
    assign n_p_dq   = 23'(n_dx) * 23'(esd_pkg::RcpDiv5);
    assign n_dq     = n_p_dq[22:14];
    assign n_day9   = 5'(r_doy8 - n_dq + 9'd1);
    assign n_month9 = (r_mp8 < 4'd10) ? (r_mp8 + 4'd3) : (r_mp8 - 4'd9);
    // january and february belong to the following civil year
    assign n_year9  = 12'(r_yoe8) + (r_era[4] ? esd_pkg::EraHiYear : esd_pkg::EraLoYear)
                      + 12'(n_month9 <= 4'd2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0      <= i_epoch_seconds;
            r_s1      <= r_s0;
            r_min1    <= n_min1;
            r_sec2    <= n_sec2;
            r_min2    <= r_min1;
            r_hr2     <= n_hr2;
            r_sec3    <= r_sec2;
            r_minute3 <= n_minute3;
            r_hr3     <= r_hr2;
            r_day3    <= n_day3;

            r_tod[0]  <= '{hour: n_hour4, minute: r_minute3, second: r_sec3};
            r_era[0]  <= n_era4;
            r_doe4    <= n_doe4;
            for (int i = 1; i < 5; i++) begin
                r_tod[i] <= r_tod[i-1];
                r_era[i] <= r_era[i-1];
            end

            r_doe5    <= r_doe4;
            r_yn5     <= n_yn5;
            r_doe6    <= r_doe5;
            r_yoe6    <= n_yoe6;
            r_doy7    <= n_doy7;
            r_yoe7    <= r_yoe6;
            r_doy8    <= r_doy7;
            r_yoe8    <= r_yoe7;
            r_mp8     <= n_mp8;

            r_year    <= n_year9;
            r_month   <= n_month9;
            r_day     <= n_day9;
            r_hour    <= r_tod[4].hour;
            r_minute  <= r_tod[4].minute;
            r_second  <= r_tod[4].second;
        end
    end

    assign o_out_valid = r_vld[esd_pkg::Stages-1];
    assign o_year      = r_year;
    assign o_month     = r_month;
    assign o_day       = r_day;
    assign o_hour      = r_hour;
    assign o_minute    = r_minute;
    assign o_second    = r_second;

    `ESD_ASSERT_IMPL(a_date_range, o_out_valid,
        o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 && o_day <= 5'd31,
        "month or day out of range")
    `ESD_ASSERT_IMPL(a_tod_range, o_out_valid,
        o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59,
        "time of day out of range")
    `ESD_ASSERT_IMPL(a_doe_range, r_vld[4], r_doe4 < esd_pkg::DaysPerEra,
        "day of era out of range")
    `ESD_ASSERT_IMPL(a_doy_range, r_vld[7], r_doy7 <= 9'd365 && r_yoe7 <= 9'd399,
        "day or year of era out of range")
    `ESD_ASSERT_NEXT(a_stage_lands, w_en && r_vld[8], o_out_valid,
        "last stage item did not reach the result register")

endmodule
